// ===== hw/rtl/pafs_pkg.sv =====
// ----------------------------------------------------------------------------
// pafs_pkg
// Shared widths, register indexes and stage payload types for the pairwise
// attraction force pipeline.
// ----------------------------------------------------------------------------
package pafs_pkg;

    // Field widths.
    localparam int POS_W    = 32;
    localparam int MASS_W   = 32;
    localparam int MD_W     = 31;
    localparam int FORCE_W  = 32;

    // Internal widths.
    localparam int DIFF_W   = POS_W + 1;          // exact coordinate difference
    localparam int SQ_W     = 2 * DIFF_W;         // squared distance
    localparam int MINS_W   = 2 * MD_W;           // squared minimum distance
    localparam int MM_W     = 2 * MASS_W;         // mass product
    localparam int NUM_W    = MM_W + 32;          // strength times mass product
    localparam int FQ_W     = SQ_W + 1;           // clamped force quotient
    localparam int ROOT_W   = SQ_W / 2;           // integer distance
    localparam int SREM_W   = ROOT_W + 2;         // square root remainder
    localparam int PROD_W   = FQ_W + DIFF_W;      // force times axis length
    localparam int CQ_W     = FORCE_W;            // component quotient
    localparam int PH_W     = PROD_W - CQ_W;

    // Step counts of the iterative units.
    localparam int SQRT_STEPS = ROOT_W;
    localparam int FDIV_STEPS = FQ_W;
    localparam int CDIV_STEPS = CQ_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd2;

    // One axis: magnitude and sign of the difference a - b.
    typedef struct packed {
        logic [DIFF_W-1:0] mag;
        logic              neg;
    } lane_t;

    // Per-item status that rides along with the data.
    typedef struct packed {
        logic fa;
        logic fb;
        logic degen;
    } flags_t;

    // Front end to quotient/root unit.
    typedef struct packed {
        logic [SQ_W-1:0]  s;
        logic [NUM_W-1:0] num;
        logic             big;
        lane_t [2:0]      lane;
        flags_t           flags;
    } front_t;

    // Quotient/root unit to component unit.
    typedef struct packed {
        logic [FQ_W-1:0]   f;
        logic              big;
        logic [ROOT_W-1:0] root;
        lane_t [2:0]       lane;
        flags_t            flags;
    } mid_out_t;

endpackage

// ===== hw/rtl/pafs_front.sv =====
// ----------------------------------------------------------------------------
// pafs_front
// Differences, squares, mass and strength products, distance clamp.
// ----------------------------------------------------------------------------
module pafs_front import pafs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [POS_W-1:0]   a_x,
    input  logic [POS_W-1:0]   a_y,
    input  logic [POS_W-1:0]   a_z,
    input  logic [POS_W-1:0]   b_x,
    input  logic [POS_W-1:0]   b_y,
    input  logic [POS_W-1:0]   b_z,
    input  logic [MASS_W-1:0]  a_mass,
    input  logic [MASS_W-1:0]  b_mass,
    input  logic               a_fixed,
    input  logic               b_fixed,
    input  logic [31:0]        strength,
    input  logic [MD_W-1:0]    min_distance,
    output logic               out_valid,
    output front_t             out_data
);

    logic [POS_W-1:0]  pa [3];
    logic [POS_W-1:0]  pb [3];
    logic [DIFF_W-1:0] diff [3];

    logic [3:0] valid_reg;

    lane_t [2:0]      s1_lane_next, s1_lane_reg, s2_lane_reg, s3_lane_reg;
    logic [MM_W-1:0]  s1_mm_next, s1_mm_reg;
    flags_t           s1_flags_reg, s2_flags_reg, s3_flags_reg;

    logic [SQ_W-1:0]   s2_sq_next [3];
    logic [SQ_W-1:0]   s2_sq_reg [3];
    logic [MINS_W-1:0] s2_mins_next, s2_mins_reg, s3_mins_reg;
    logic [31:0]       kmag;
    logic [63:0]       s2_nlo_next, s2_nlo_reg, s2_nhi_next, s2_nhi_reg;

    logic [SQ_W-1:0]  s3_ssum_next, s3_ssum_reg;
    logic [NUM_W-1:0] s3_num_next, s3_num_reg;

    logic [SQ_W-1:0]  clamp;
    front_t           out_next;

    assign pa[0] = a_x;
    assign pa[1] = a_y;
    assign pa[2] = a_z;
    assign pb[0] = b_x;
    assign pb[1] = b_y;
    assign pb[2] = b_z;

    // Stage 1: exact differences split into magnitude and sign.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {pa[i][POS_W-1], pa[i]} - {pb[i][POS_W-1], pb[i]};
            s1_lane_next[i].neg = diff[i][DIFF_W-1];
            s1_lane_next[i].mag = diff[i][DIFF_W-1] ? (DIFF_W'(0) - diff[i]) : diff[i];
        end
    end

    assign s1_mm_next = a_mass * b_mass;

    // Stage 2: squares and partial products of the numerator.
    assign kmag = strength[31] ? (32'd0 - strength) : strength;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_sq_next[i] = s1_lane_reg[i].mag * s1_lane_reg[i].mag;
        end
    end

    assign s2_mins_next = min_distance * min_distance;
    assign s2_nlo_next  = s1_mm_reg[31:0] * kmag;
    assign s2_nhi_next  = s1_mm_reg[MM_W-1:32] * kmag;

    // Stage 3: sum of squares and full numerator.
    assign s3_ssum_next = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
    assign s3_num_next  = {s2_nhi_reg, 32'd0} + NUM_W'(s2_nlo_reg);

    // Stage 4: clamp, zero-distance flag and quotient overflow check.
    always_comb
    begin
        clamp = (s3_ssum_reg < SQ_W'(s3_mins_reg)) ? SQ_W'(s3_mins_reg) : s3_ssum_reg;
        out_next = '0;
        out_next.flags = s3_flags_reg;
        out_next.flags.degen = (clamp == '0);
        out_next.s = (clamp == '0) ? SQ_W'(1) : clamp;
        out_next.num = s3_num_reg;
        out_next.big = SQ_W'(s3_num_reg[NUM_W-1:FQ_W]) >= out_next.s;
        out_next.lane = s3_lane_reg;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_lane_reg  <= s1_lane_next;
            s1_mm_reg    <= s1_mm_next;
            s1_flags_reg <= '{fa: a_fixed, fb: b_fixed, degen: 1'b0};

            s2_sq_reg    <= s2_sq_next;
            s2_mins_reg  <= s2_mins_next;
            s2_nlo_reg   <= s2_nlo_next;
            s2_nhi_reg   <= s2_nhi_next;
            s2_lane_reg  <= s1_lane_reg;
            s2_flags_reg <= s1_flags_reg;

            s3_ssum_reg  <= s3_ssum_next;
            s3_num_reg   <= s3_num_next;
            s3_mins_reg  <= s2_mins_reg;
            s3_lane_reg  <= s2_lane_reg;
            s3_flags_reg <= s2_flags_reg;

            out_data     <= out_next;
        end
    end

    assign out_valid = valid_reg[3];

endmodule

// ===== hw/rtl/pafs_mid.sv =====
// ----------------------------------------------------------------------------
// pafs_mid
// Pipelined restoring division of the numerator by the clamped squared
// distance, with a digit-by-digit square root in the first stages.
// ----------------------------------------------------------------------------
module pafs_mid import pafs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  front_t   in_data,
    output logic     out_valid,
    output mid_out_t out_data
);

    typedef struct packed {
        logic [SQ_W-1:0]   s;
        logic [SQ_W-1:0]   r;
        logic [FQ_W-1:0]   q;
        logic [FQ_W-1:0]   nsh;
        logic              big;
        logic [ROOT_W-1:0] root;
        logic [SREM_W-1:0] srem;
        lane_t [2:0]       lane;
        flags_t            flags;
    } mid_t;

    mid_t                  head;
    mid_t                  stage_next [FDIV_STEPS];
    mid_t                  stage_reg  [FDIV_STEPS];
    logic [FDIV_STEPS-1:0] valid_reg;

    // Initial partial remainder holds the numerator bits above the quotient.
    always_comb
    begin
        head = '0;
        head.s = in_data.s;
        head.r = SQ_W'(in_data.num[NUM_W-1:FQ_W]);
        head.nsh = in_data.num[FQ_W-1:0];
        head.big = in_data.big;
        head.lane = in_data.lane;
        head.flags = in_data.flags;
    end

    for (genvar j = 0; j < FDIV_STEPS; j++)
    begin : g_stage
        mid_t              prev;
        logic [ROOT_W-1:0] root_n;
        logic [SREM_W-1:0] srem_n;

        if (j == 0)
        begin : g_head
            assign prev = head;
        end
        else
        begin : g_tail
            assign prev = stage_reg[j-1];
        end

        // One root digit per stage while pairs of bits remain.
        if (j < SQRT_STEPS)
        begin : g_sqrt
            localparam int K = SQRT_STEPS - 1 - j;
            logic [SREM_W-1:0] rt;
            logic [SREM_W-1:0] trial;

            always_comb
            begin
                rt = {prev.srem[SREM_W-3:0], prev.s[2*K+1 -: 2]};
                trial = {prev.root, 2'b01};
                if (rt >= trial)
                begin
                    srem_n = rt - trial;
                    root_n = {prev.root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_n = rt;
                    root_n = {prev.root[ROOT_W-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_hold
            assign root_n = prev.root;
            assign srem_n = prev.srem;
        end

        // One quotient bit per stage.
        always_comb
        begin
            logic [FQ_W-1:0] t;
            t = {prev.r, prev.nsh[FQ_W-1]};
            stage_next[j] = prev;
            stage_next[j].nsh = {prev.nsh[FQ_W-2:0], 1'b0};
            stage_next[j].root = root_n;
            stage_next[j].srem = srem_n;
            if (t >= {1'b0, prev.s})
            begin
                stage_next[j].r = SQ_W'(t - {1'b0, prev.s});
                stage_next[j].q = {prev.q[FQ_W-2:0], 1'b1};
            end
            else
            begin
                stage_next[j].r = t[SQ_W-1:0];
                stage_next[j].q = {prev.q[FQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[FDIV_STEPS-2:0], in_valid};
        end
    end

    assign out_valid      = valid_reg[FDIV_STEPS-1];
    assign out_data.f     = stage_reg[FDIV_STEPS-1].q;
    assign out_data.big   = stage_reg[FDIV_STEPS-1].big;
    assign out_data.root  = stage_reg[FDIV_STEPS-1].root;
    assign out_data.lane  = stage_reg[FDIV_STEPS-1].lane;
    assign out_data.flags = stage_reg[FDIV_STEPS-1].flags;

endmodule

// ===== hw/rtl/pafs_comp.sv =====
// ----------------------------------------------------------------------------
// pafs_comp
// Per-axis scaling by the axis length, division by the distance, sign,
// saturation and the output register.
// ----------------------------------------------------------------------------
module pafs_comp import pafs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  mid_out_t           in_data,
    input  logic [31:0]        strength,
    input  logic               enable,
    output logic               out_valid,
    output logic [FORCE_W-1:0] force_x,
    output logic [FORCE_W-1:0] force_y,
    output logic [FORCE_W-1:0] force_z,
    output logic               apply_a,
    output logic               apply_b,
    output logic               degenerate
);

    typedef struct packed {
        logic [ROOT_W-1:0] r;
        logic [CQ_W-1:0]   pl;
        logic [CQ_W-1:0]   q;
        logic              sat;
        logic              neg;
    } cd_lane_t;

    typedef struct packed {
        cd_lane_t [2:0]    lane;
        logic [ROOT_W-1:0] root;
        flags_t            flags;
    } cd_t;

    // Stage B1 registers.
    logic [CQ_W+DIFF_W-1:0] b1_plo_reg [3];
    logic [PH_W-1:0]        b1_phi_reg [3];
    logic                   b1_big_reg;
    logic [ROOT_W-1:0]      b1_root_reg;
    lane_t [2:0]            b1_lane_reg;
    flags_t                 b1_flags_reg;

    cd_t                    b2_next;
    cd_t                    cd_next [CDIV_STEPS];
    cd_t                    cd_reg  [CDIV_STEPS+1];
    logic [CDIV_STEPS+1:0]  valid_reg;

    logic [PROD_W-1:0]      p [3];
    logic [FORCE_W-1:0]     res [3];
    logic                   active;
    logic                   out_valid_reg;

    // Stage B2: full product, overflow check and initial remainder.
    always_comb
    begin
        b2_next = '0;
        b2_next.root = b1_root_reg;
        b2_next.flags = b1_flags_reg;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = {b1_phi_reg[i], 32'd0} + PROD_W'(b1_plo_reg[i]);
            b2_next.lane[i].neg = b1_lane_reg[i].neg;
            b2_next.lane[i].sat = b1_big_reg ? (b1_lane_reg[i].mag != '0)
                                             : (p[i][PROD_W-1:CQ_W] >= PH_W'(b1_root_reg));
            b2_next.lane[i].r  = p[i][CQ_W+ROOT_W-1:CQ_W];
            b2_next.lane[i].pl = p[i][CQ_W-1:0];
            b2_next.lane[i].q  = '0;
        end
    end

    // Division stages, one quotient bit per lane each.
    for (genvar j = 0; j < CDIV_STEPS; j++)
    begin : g_cdiv
        always_comb
        begin
            logic [ROOT_W:0] t;
            cd_next[j] = cd_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                t = {cd_reg[j].lane[i].r, cd_reg[j].lane[i].pl[CQ_W-1]};
                cd_next[j].lane[i].pl = {cd_reg[j].lane[i].pl[CQ_W-2:0], 1'b0};
                if (t >= {1'b0, cd_reg[j].root})
                begin
                    cd_next[j].lane[i].r = ROOT_W'(t - {1'b0, cd_reg[j].root});
                    cd_next[j].lane[i].q = {cd_reg[j].lane[i].q[CQ_W-2:0], 1'b1};
                end
                else
                begin
                    cd_next[j].lane[i].r = t[ROOT_W-1:0];
                    cd_next[j].lane[i].q = {cd_reg[j].lane[i].q[CQ_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_reg[j+1] <= cd_next[j];
            end
        end
    end

    // Sign and saturation of each component.
    always_comb
    begin
        logic [CQ_W:0] mag;
        logic          neg;
        for (int i = 0; i < 3; i++)
        begin
            mag = cd_reg[CDIV_STEPS].lane[i].sat ? {1'b1, CQ_W'(0)}
                                                 : {1'b0, cd_reg[CDIV_STEPS].lane[i].q};
            neg = strength[31] ^ cd_reg[CDIV_STEPS].lane[i].neg;
            if (neg)
            begin
                res[i] = (mag >= {2'b01, (CQ_W-1)'(0)}) ? {1'b1, (FORCE_W-1)'(0)}
                                                         : FORCE_W'((CQ_W+1)'(0) - mag);
            end
            else
            begin
                res[i] = (mag > {2'b00, {(CQ_W-1){1'b1}}}) ? {1'b0, {(FORCE_W-1){1'b1}}}
                                                           : mag[FORCE_W-1:0];
            end
        end
    end

    assign active = enable & ~(cd_reg[CDIV_STEPS].flags.fa & cd_reg[CDIV_STEPS].flags.fb);

    // Valid bits travel with the data; the last one feeds the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[CDIV_STEPS:0], in_valid};
            out_valid_reg <= valid_reg[CDIV_STEPS+1];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b1_plo_reg[i] <= in_data.f[CQ_W-1:0] * in_data.lane[i].mag;
                b1_phi_reg[i] <= in_data.f[FQ_W-1:CQ_W] * in_data.lane[i].mag;
            end
            b1_big_reg   <= in_data.big;
            b1_root_reg  <= in_data.root;
            b1_lane_reg  <= in_data.lane;
            b1_flags_reg <= in_data.flags;
            cd_reg[0]    <= b2_next;

            if (!active || cd_reg[CDIV_STEPS].flags.degen)
            begin
                force_x <= '0;
                force_y <= '0;
                force_z <= '0;
            end
            else
            begin
                force_x <= res[0];
                force_y <= res[1];
                force_z <= res[2];
            end
            apply_a    <= active & ~cd_reg[CDIV_STEPS].flags.fa;
            apply_b    <= active & ~cd_reg[CDIV_STEPS].flags.fb;
            degenerate <= active & cd_reg[CDIV_STEPS].flags.degen;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/pairwise_attraction_force.sv =====
// ----------------------------------------------------------------------------
// pairwise_attraction_force
// Inverse-square force between one particle pair per request, Q16.16.
// ----------------------------------------------------------------------------
// The block takes one particle pair per clock while the output side does not
// stall, and returns one force result for each, in order. Most of its depth
// lies in the 67-stage quotient pipeline that divides strength times both
// masses by the clamped squared distance (the square root of the distance
// runs in its first 33 stages), followed by the 32-stage per-axis division
// by the distance. A stall on the output freezes the whole pipeline;
// in_ready is low only while a finished result waits. Configuration is
// written through cfg_wen, cfg_index and cfg_wdata; the user must write it
// only while no request is in flight, and the block does not enforce this.
// ----------------------------------------------------------------------------
module pairwise_attraction_force import pafs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [POS_W-1:0]     a_x,
    input  logic [POS_W-1:0]     a_y,
    input  logic [POS_W-1:0]     a_z,
    input  logic [POS_W-1:0]     b_x,
    input  logic [POS_W-1:0]     b_y,
    input  logic [POS_W-1:0]     b_z,
    input  logic [MASS_W-1:0]    a_mass,
    input  logic [MASS_W-1:0]    b_mass,
    input  logic                 a_fixed,
    input  logic                 b_fixed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FORCE_W-1:0]   force_x,
    output logic [FORCE_W-1:0]   force_y,
    output logic [FORCE_W-1:0]   force_z,
    output logic                 apply_a,
    output logic                 apply_b,
    output logic                 degenerate
);

    logic [31:0]     strength_reg;
    logic [MD_W-1:0] min_dist_reg;
    logic            enable_reg;
    logic            adv;
    logic            front_valid;
    front_t          front_data;
    logic            mid_valid;
    mid_out_t        mid_data;

    // The pipeline moves unless a finished result is waiting.
    assign adv      = ~out_valid | out_ready;
    assign in_ready = adv;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= 32'd65536;
            min_dist_reg <= MD_W'(65536);
            enable_reg   <= 1'b1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_STRENGTH: strength_reg <= cfg_wdata;
                REG_MIN_DIST: min_dist_reg <= cfg_wdata[MD_W-1:0];
                REG_ENABLE:   enable_reg   <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    pafs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .a_mass       (a_mass),
        .b_mass       (b_mass),
        .a_fixed      (a_fixed),
        .b_fixed      (b_fixed),
        .strength     (strength_reg),
        .min_distance (min_dist_reg),
        .out_valid    (front_valid),
        .out_data     (front_data)
    );

    pafs_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (mid_valid),
        .out_data  (mid_data)
    );

    pafs_comp u_comp (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (mid_valid),
        .in_data    (mid_data),
        .strength   (strength_reg),
        .enable     (enable_reg),
        .out_valid  (out_valid),
        .force_x    (force_x),
        .force_y    (force_y),
        .force_z    (force_z),
        .apply_a    (apply_a),
        .apply_b    (apply_b),
        .degenerate (degenerate)
    );

endmodule

// ===== hw/rtl/pafs_checker.sv =====
// ----------------------------------------------------------------------------
// pafs_checker
// Port-level checks of the pairwise attraction force block.
// ----------------------------------------------------------------------------
module pafs_checker import pafs_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FORCE_W-1:0] force_x,
    input logic [FORCE_W-1:0] force_y,
    input logic [FORCE_W-1:0] force_z,
    input logic               apply_a,
    input logic               apply_b,
    input logic               degenerate
);

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(force_x)
            && $stable(force_y) && $stable(force_z))
        else $error("stalled result changed");

    // The input side stalls while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // A zero distance gives a zero force.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> force_x == '0 && force_y == '0 && force_z == '0)
        else $error("degenerate result with nonzero force");

    // No particle takes a force: the force is zero and not degenerate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !apply_a && !apply_b |-> !degenerate && force_x == '0
            && force_y == '0 && force_z == '0)
        else $error("inactive result with nonzero fields");

endmodule

bind pairwise_attraction_force pafs_checker u_pafs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .force_x    (force_x),
    .force_y    (force_y),
    .force_z    (force_z),
    .apply_a    (apply_a),
    .apply_b    (apply_b),
    .degenerate (degenerate)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pairwise attraction force pipeline. A short
// table of directed pairs runs first, followed by random pairs under several
// register settings and handshake idling patterns. Every result is compared
// field by field with an in-order queue of typed or bit-exact predicted forces.
// ----------------------------------------------------------------------------
module testbench;
    import pafs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] ax, ay, az, bx, by, bz;
        logic [31:0] a_mass, b_mass;
        logic        a_fixed, b_fixed;
    } pair_t;

    typedef struct packed {
        logic [31:0] fx, fy, fz;
        logic        apply_a, apply_b, degen;
    } force_t;

    typedef struct packed {
        logic [31:0] strength;
        logic [30:0] min_dist;
        logic        enable;
        pair_t       pair;
        logic        typed;
        force_t      want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    pair_t       req = '0;
    force_t      got;

    // Mirror of the register file.
    logic [31:0] cfg_strength = 32'd65536;
    logic [30:0] cfg_min_dist = 31'd65536;
    logic        cfg_enable = 1'b1;

    // Expectation attached to the request currently on the input.
    logic        cur_typed = 1'b0;
    force_t      cur_want = '0;

    force_t      pending_forces[$];
    int          accepted = 0;
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #5 clk = ~clk;

    pairwise_attraction_force dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(req.ax), .a_y(req.ay), .a_z(req.az),
        .b_x(req.bx), .b_y(req.by), .b_z(req.bz),
        .a_mass(req.a_mass), .b_mass(req.b_mass),
        .a_fixed(req.a_fixed), .b_fixed(req.b_fixed),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(got.fx), .force_y(got.fy), .force_z(got.fz),
        .apply_a(got.apply_a), .apply_b(got.apply_b), .degenerate(got.degen)
    );

    // Exact force on particle b for one pair under the current registers.
    function automatic force_t predict_force(pair_t p);
        logic [32:0]  dd;
        logic [129:0] mag[3];
        logic         dneg[3];
        logic [129:0] s, mins, lo, hi, mid, num, f, c, kmag;
        logic [31:0]  pa[3], pb[3];
        logic         neg;
        force_t       r;
        r = '0;
        if (!cfg_enable || (p.a_fixed && p.b_fixed))
            return r;
        r.apply_a = !p.a_fixed;
        r.apply_b = !p.b_fixed;
        pa = '{p.ax, p.ay, p.az};
        pb = '{p.bx, p.by, p.bz};
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            dd = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
            dneg[i] = dd[32];
            mag[i] = dd[32] ? 130'(-dd) & 130'h1_FFFF_FFFF : 130'(dd);
            s = s + mag[i] * mag[i];
        end
        mins = 130'(cfg_min_dist) * 130'(cfg_min_dist);
        if (s < mins)
            s = mins;
        if (s == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        // Integer square root by bisection.
        lo = '0;
        hi = 130'(1) << 34;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (s < mid * mid)
                hi = mid;
            else
                lo = mid;
        end
        kmag = cfg_strength[31] ? 130'(-{1'b1, cfg_strength}) & 130'h1_FFFF_FFFF
                                : 130'(cfg_strength);
        num = 130'(p.a_mass) * 130'(p.b_mass) * kmag;
        f = num / s;
        for (int i = 0; i < 3; i++)
        begin
            c = (f * mag[i]) / lo;
            neg = cfg_strength[31] != dneg[i];
            if (neg)
                pa[i] = (c >= 130'h8000_0000) ? 32'h8000_0000 : -c[31:0];
            else
                pa[i] = (c > 130'h7FFF_FFFF) ? 32'h7FFF_FFFF : c[31:0];
        end
        r.fx = pa[0];
        r.fy = pa[1];
        r.fz = pa[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] g, logic [31:0] w);
        $display("mismatch %s: got %h expected %h", what, g, w);
        errors++;
    endtask

    // Record accepted requests and check finished results.
    always @(posedge clk)
    begin
        force_t w;
        if (in_valid && in_ready)
        begin
            pending_forces.push_back(cur_typed ? cur_want : predict_force(req));
            accepted++;
        end
        if (out_valid && out_ready)
        begin
            if (pending_forces.size() == 0)
            begin
                report_mismatch("unexpected result", got.fx, '0);
            end
            else
            begin
                w = pending_forces.pop_front();
                if (got.fx !== w.fx) report_mismatch("force_x", got.fx, w.fx);
                if (got.fy !== w.fy) report_mismatch("force_y", got.fy, w.fy);
                if (got.fz !== w.fz) report_mismatch("force_z", got.fz, w.fz);
                if (got.apply_a !== w.apply_a)
                    report_mismatch("apply_a", 32'(got.apply_a), 32'(w.apply_a));
                if (got.apply_b !== w.apply_b)
                    report_mismatch("apply_b", 32'(got.apply_b), 32'(w.apply_b));
                if (got.degen !== w.degen)
                    report_mismatch("degenerate", 32'(got.degen), 32'(w.degen));
            end
        end
    end

    // Receiver stalls.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Registers change only with nothing in flight.
    task automatic set_config(logic [31:0] st, logic [30:0] md, logic en);
        while (pending_forces.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(REG_STRENGTH, st);
        write_reg(REG_MIN_DIST, {1'($urandom_range(1)), md});
        write_reg(REG_ENABLE, {31'($urandom), en});
        write_reg(REG_UNUSED, $urandom);
        cfg_strength = st;
        cfg_min_dist = md;
        cfg_enable = en;
    endtask

    // Present one request and hold it until taken, then idle at random.
    task automatic send_pair(pair_t p, logic typed, force_t want);
        int seen;
        seen = accepted;
        req <= p;
        cur_typed <= typed;
        cur_want <= want;
        in_valid <= 1'b1;
        do @(negedge clk); while (accepted == seen);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        int kind;
        logic [31:0] ext[4];
        ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        kind = $urandom_range(9);
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, 2'b00};
        if (kind <= 5)
        begin
            // Nearby particles with modest masses.
            p.ax = p.bx + $signed($urandom_range(2 << 20) - (1 << 20));
            p.ay = p.by + $signed($urandom_range(2 << 20) - (1 << 20));
            p.az = p.bz + $signed($urandom_range(2 << 20) - (1 << 20));
            p.a_mass = $urandom_range(1 << 20);
            p.b_mass = $urandom_range(1 << 20);
        end
        else if (kind == 8)
        begin
            p.ax = ext[$urandom_range(3)];
            p.ay = ext[$urandom_range(3)];
            p.az = ext[$urandom_range(3)];
            p.bx = ext[$urandom_range(3)];
            p.by = ext[$urandom_range(3)];
            p.bz = ext[$urandom_range(3)];
            p.a_mass = ext[$urandom_range(3)];
            p.b_mass = ext[$urandom_range(3)];
        end
        else if (kind == 9)
        begin
            // Coincident particles.
            p.ax = p.bx;
            p.ay = p.by;
            p.az = p.bz;
        end
        p.a_fixed = ($urandom_range(3) == 0);
        p.b_fixed = ($urandom_range(3) == 0);
        return p;
    endfunction

    localparam int NUM_ROWS = 14;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] FF = 32'hFFFF_FFFF;

    // Directed pairs: strength, min distance, enable, pair, typed result.
    row_t directed[NUM_ROWS] = '{
        '{ONE, 31'h10000, 1'b1, '{ONE, 0, 0, 0, 0, 0, ONE, ONE, 1'b0, 1'b0},
          1'b0, '0},
        '{ONE, 31'h10000, 1'b1, '{5, 7, 9, 5, 7, 9, ONE, ONE, 1'b0, 1'b0},
          1'b1, '{0, 0, 0, 1'b1, 1'b1, 1'b0}},
        '{ONE, 31'h10000, 1'b1, '{ONE, ONE, ONE, 0, 0, 0, ONE, ONE, 1'b1, 1'b1},
          1'b1, '0},
        '{ONE, 31'h10000, 1'b1, '{0, ONE, 0, 0, 0, 0, ONE, ONE, 1'b1, 1'b0},
          1'b0, '0},
        '{ONE, 31'h10000, 1'b1, '{0, 0, ONE, 0, 0, 0, ONE, ONE, 1'b0, 1'b1},
          1'b0, '0},
        '{ONE, 31'h10000, 1'b1, '{MX, MX, MX, MN, MN, MN, FF, FF, 1'b0, 1'b0},
          1'b0, '0},
        '{ONE, 31'h10000, 1'b1, '{MN, MN, MN, MX, MX, MX, 0, FF, 1'b0, 1'b0},
          1'b0, '0},
        '{MX, 31'h0, 1'b1, '{1, 0, 0, 0, 0, 0, FF, FF, 1'b0, 1'b0},
          1'b0, '0},
        '{MN, 31'h0, 1'b1, '{0, 1, FF, 0, 0, 0, FF, FF, 1'b0, 1'b0},
          1'b0, '0},
        '{MN, 31'h0, 1'b1, '{ONE, 2, 3, ONE, 2, 3, FF, FF, 1'b0, 1'b1},
          1'b1, '{0, 0, 0, 1'b1, 1'b0, 1'b1}},
        '{MN, 31'h7FFF_FFFF, 1'b1, '{MX, 0, 0, MN, 0, 0, FF, FF, 1'b0, 1'b0},
          1'b0, '0},
        '{0, 31'h10000, 1'b1, '{ONE, 0, 0, 0, 0, 0, FF, FF, 1'b0, 1'b0},
          1'b1, '{0, 0, 0, 1'b1, 1'b1, 1'b0}},
        '{ONE, 31'h10000, 1'b0, '{ONE, 0, 0, 0, 0, 0, ONE, ONE, 1'b0, 1'b0},
          1'b1, '0},
        '{ONE, 31'h10000, 1'b0, '{0, 0, 0, 0, 0, 0, FF, FF, 1'b0, 1'b0},
          1'b1, '0}
    };

    // Main sequence.
    initial
    begin
        logic [31:0] st;
        logic [30:0] md;
        logic        en;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].strength != cfg_strength ||
                directed[i].min_dist != cfg_min_dist ||
                directed[i].enable != cfg_enable)
            begin
                in_valid <= 1'b0;
                set_config(directed[i].strength, directed[i].min_dist,
                           directed[i].enable);
            end
            send_pair(directed[i].pair, directed[i].typed, directed[i].want);
        end

        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle_pct = (ph < 3) ? 20 : (ph < 6) ? 67 : 0;
            recv_stall_pct = (ph < 3) ? 67 : (ph < 6) ? 20 : 0;
            st = $urandom;
            md = 31'($urandom_range(1 << 20));
            en = 1'b1;
            case (ph)
                0: begin st = ONE; md = 31'h10000; end
                1: begin st = MX; md = '0; end
                2: begin st = MN; md = 31'h7FFF_FFFF; end
                4: en = 1'b0;
                5: st = '0;
                6: md = 31'($urandom);
                default: ;
            endcase
            in_valid <= 1'b0;
            set_config(st, md, en);
            for (int n = 0; n < 150; n++)
                send_pair(random_pair(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_forces.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pafs_pkg.sv
hw/rtl/pafs_front.sv
hw/rtl/pafs_mid.sv
hw/rtl/pafs_comp.sv
hw/rtl/pairwise_attraction_force.sv
hw/rtl/pafs_checker.sv
sim/testbench.sv
